@@ design/slu_pkg.sv @@
// shared types and constants for the string literal unescaper
// depends on nothing; used by the decoder, the result queue and the top level
package slu_pkg;

  // status codes of a result
  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_LONG   = 2'd2;
  localparam logic [1:0] ST_UNTERM = 2'd3;

  // decoder modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;

  // characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int          COUNT_W   = 17;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  // configuration register indexes
  localparam int          PADDR_W     = 3;
  localparam logic [0:0]  REG_MAX_LEN = 1'b0;

  // result queue
  localparam int SLU_FIFO_DEPTH = 4;
  localparam int SLU_PTR_W      = $clog2(SLU_FIFO_DEPTH);
  localparam int SLU_CNT_W      = $clog2(SLU_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       last;
  } slu_result_t;

  // results caused by one accepted item
  typedef struct packed {
    logic [1:0]  n;
    slu_result_t r0;
    slu_result_t r1;
  } slu_dec_t;

endpackage

@@ design/slu_stream_if.sv @@
// valid/ready channel interfaces for source bytes and decoded results
// depends on nothing
interface slu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       source_end;

  modport source (output valid, output ch, output source_end, input ready);
  modport sink (input valid, input ch, input source_end, output ready);
endinterface

interface slu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_char, output status, output last, input ready);
  modport sink (input valid, input out_char, input status, input last, output ready);
endinterface

@@ design/string_literal_unescaper_top.sv @@
// Top level of the string literal unescaper.
// Depends on slu_pkg, slu_stream_if, slu_decoder and slu_out_fifo.
//
// Use:
//   in_if  : source bytes, one per transfer; source_end marks end of source
//            and carries no byte. Bytes outside a literal are dropped.
//   out_if : decoded results {out_char, status, last}; status is byte, done,
//            too long or unterminated, and last marks the final result.
//   APB    : one register, max_length at byte address 0 (reset 65535).
//            Write only while no transfer is in flight.
// Timing:
//   a transfer's results are registered in the result queue and offered from it in order.
//   One source byte is taken every cycle while in_if.ready is high; an unknown
//   escape yields two results, which leave by two output transfers.
//   The rate is set by the four-entry result queue: in_if.ready is high
//   while at least two entries are free.
// Reset (rst_n low, synchronous): decoder idle, queue empty, limit 65535.
// Output stall: results wait in the queue; input keeps flowing until fewer
//   than two entries remain, then in_if.ready drops until the receiver drains.
module string_literal_unescaper_top (
  input  logic                        clk,
  input  logic                        rst_n,
  slu_in_if.sink                      in_if,
  slu_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import slu_pkg::*;

  logic        fire;
  logic        room;
  logic        cfg_wr;
  logic [15:0] max_len_r;
  slu_dec_t    dec;
  slu_result_t res;

  // register index sits above the word offset
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN);
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'h0000, max_len_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= pwdata[15:0];
    end
  end

  // input transfer completes when the queue can hold two more results
  assign in_if.ready = room;
  assign fire        = in_if.valid && room;

  slu_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .ch         (in_if.ch),
    .source_end (in_if.source_end),
    .max_len    (max_len_r),
    .dec        (dec)
  );

  slu_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .room      (room),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  assign out_if.out_char = res.out_char;
  assign out_if.status   = res.status;
  assign out_if.last     = res.last;

`ifndef SYNTH
  a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.last == (out_if.status != ST_BYTE))
    else $error("last flag disagrees with status");
  a_byte_zero_else: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.status != ST_BYTE |-> out_if.out_char == 8'h00)
    else $error("nonzero char on a status result");
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !room |-> dec.n == 2'd0) else $error("results produced without queue room");
`endif

endmodule

@@ design/slu_decoder.sv @@
// escape decoder: mode and body count registers plus next-state and result logic
// depends on slu_pkg
module slu_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        ch,
  input  logic              source_end,
  input  logic [15:0]       max_len,
  output slu_pkg::slu_dec_t dec
);
  import slu_pkg::*;

  logic [1:0]         mode_r, mode_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] count_inc;
  logic               over_limit;

  assign count_inc  = (count_r < COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
  assign over_limit = count_r >= {1'b0, max_len};

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    dec       = '0;
    if (source_end) begin
      if (mode_r == MODE_BODY || mode_r == MODE_ESC) begin
        dec.n         = 2'd1;
        dec.r0.status = ST_UNTERM;
        dec.r0.last   = 1'b1;
        count_nxt     = '0;
      end
      mode_nxt = MODE_IDLE;
    end else begin
      case (mode_r)
        MODE_BODY: begin
          if (ch == CH_QUOTE) begin
            dec.n         = 2'd1;
            dec.r0.status = ST_DONE;
            dec.r0.last   = 1'b1;
            mode_nxt      = MODE_IDLE;
            count_nxt     = '0;
          end else if (over_limit) begin
            dec.n         = 2'd1;
            dec.r0.status = ST_LONG;
            dec.r0.last   = 1'b1;
            mode_nxt      = MODE_IDLE;
            count_nxt     = '0;
          end else begin
            count_nxt = count_inc;
            if (ch == CH_BSLASH) begin
              mode_nxt = MODE_ESC;
            end else begin
              dec.n           = 2'd1;
              dec.r0.out_char = ch;
            end
          end
        end
        MODE_ESC: begin
          count_nxt = count_inc;
          mode_nxt  = MODE_BODY;
          dec.n     = 2'd1;
          case (ch)
            CH_N:      dec.r0.out_char = CH_LF;
            CH_T:      dec.r0.out_char = CH_TAB;
            CH_R:      dec.r0.out_char = CH_CR;
            CH_BSLASH, CH_QUOTE, CH_LBRACE, CH_RBRACE: dec.r0.out_char = ch;
            default: begin
              // unknown escape keeps the backslash
              dec.n           = 2'd2;
              dec.r0.out_char = CH_BSLASH;
              dec.r1.out_char = ch;
            end
          endcase
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (ch == CH_QUOTE) begin
            mode_nxt  = MODE_BODY;
            count_nxt = '0;
          end
        end
      endcase
    end
    if (!fire) begin
      dec.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != 2'd3) else $error("decoder mode code unused");
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> count_r == '0) else $error("count not cleared while idle");
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && source_end |=> mode_r == MODE_IDLE) else $error("source end left literal open");
`endif

endmodule

@@ design/slu_out_fifo.sv @@
// small result queue: takes up to two results per cycle, hands out one per transfer
// depends on slu_pkg
module slu_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slu_pkg::slu_dec_t    dec,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slu_pkg::slu_result_t out_res
);
  import slu_pkg::*;

  slu_result_t          mem [SLU_FIFO_DEPTH];
  logic [SLU_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SLU_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [SLU_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = cnt_r != '0;
  assign out_res    = mem[rd_ptr_r];
  assign room       = cnt_r <= SLU_CNT_W'(SLU_FIFO_DEPTH - 2);
  assign wr_ptr_nxt = wr_ptr_r + SLU_PTR_W'(dec.n);
  assign rd_ptr_nxt = rd_ptr_r + SLU_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + SLU_CNT_W'(dec.n) - SLU_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (dec.n != 2'd0) begin
      mem[wr_ptr_r] <= dec.r0;
    end
    if (dec.n == 2'd2) begin
      mem[wr_ptr_r + SLU_PTR_W'(1)] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    dec.n != 2'd0 |-> cnt_r + SLU_CNT_W'(dec.n) <= SLU_CNT_W'(SLU_FIFO_DEPTH))
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLU_CNT_W'(SLU_FIFO_DEPTH)) else $error("result count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != SLU_CNT_W'(SLU_FIFO_DEPTH) |->
      SLU_CNT_W'(SLU_PTR_W'(wr_ptr_r - rd_ptr_r)) == cnt_r)
    else $error("queue pointers disagree with count");
`endif

endmodule
